// ===== rtl/tisp_pkg.sv =====
`default_nettype none

package tisp_pkg;

  localparam logic [7:0] C_IAC  = 8'd255;
  localparam logic [7:0] C_SB   = 8'd250;
  localparam logic [7:0] C_SE   = 8'd240;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_DO   = 8'd253;
  localparam logic [7:0] C_DONT = 8'd254;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_COMPORT = 8'd44;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_SUB   = 2'd2,
    KIND_EMPTY = 2'd3
  } out_kind_e;

  typedef enum logic [2:0] {
    SRC_DATA      = 3'd0,
    SRC_REPLY_IAC = 3'd1,
    SRC_REPLY_ANS = 3'd2,
    SRC_REPLY_OPT = 3'd3,
    SRC_EMPTY     = 3'd4,
    SRC_RUN       = 3'd5
  } out_src_e;

  typedef struct packed {
    logic      save_cmd;
    logic      reply_save;
    logic      clr_sub;
    logic      store_en;
    logic      out_load;
    out_src_e  out_src;
    logic      run_start;
    logic      run_active;
    logic      run_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_iac;
    logic is_sb;
    logic is_se;
    logic is_cmd;
    logic cmd_known;
    logic cnt_zero;
    logic run_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tisp_dp.sv =====
`default_nettype none

module tisp_dp #(
  parameter int SubnegDepth = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        byte_in_i,
  input  wire tisp_pkg::dp_cmd_t cmd_i,
  output tisp_pkg::dp_stat_t     stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [1:0]             out_kind_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_o,
  output logic                   truncated_o
);
  import tisp_pkg::*;

  localparam int IdxW = $clog2(SubnegDepth);
  localparam int CntW = $clog2(SubnegDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(SubnegDepth);

  logic [7:0]      mem_q [SubnegDepth];
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] rd_addr;

  logic [7:0]      pend_q;
  logic [7:0]      ans_q, ans_d;
  logic [7:0]      opt_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            full;
  logic            agreed;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_kind_q, out_kind_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            last_q, last_d;
  logic            trunc_q, trunc_d;

  assign full = (cnt_q == DepthCnt);

  assign agreed = (byte_in_i == OPT_BINARY) || (byte_in_i == OPT_ECHO) ||
                  (byte_in_i == OPT_SGA) || (byte_in_i == OPT_COMPORT);

  always_comb begin
    unique case (pend_q)
      C_DO:    ans_d = agreed ? C_WILL : C_WONT;
      C_WILL:  ans_d = agreed ? C_DO : C_DONT;
      C_DONT:  ans_d = C_WONT;
      C_WONT:  ans_d = C_DONT;
      default: ans_d = 8'd0;
    endcase
  end

  always_comb begin
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.is_iac    = (byte_in_i == C_IAC);
    stat_o.is_sb     = (byte_in_i == C_SB);
    stat_o.is_se     = (byte_in_i == C_SE);
    stat_o.is_cmd    = (byte_in_i == C_WILL) || (byte_in_i == C_WONT) ||
                       (byte_in_i == C_DO) || (byte_in_i == C_DONT);
    stat_o.cmd_known = (pend_q == C_WILL) || (pend_q == C_WONT) ||
                       (pend_q == C_DO) || (pend_q == C_DONT);
    stat_o.cnt_zero  = (cnt_q == '0);
    stat_o.run_last  = ((CntW'(idx_q) + CntW'(1)) == cnt_q);
  end

  // subnegotiation store count and overflow flag
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.clr_sub) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (cmd_i.store_en) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.run_start) begin
      idx_d = '0;
    end else if (cmd_i.run_step) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  // read address runs one ahead of the output load so the data is ready in time
  always_comb begin
    if (!cmd_i.run_active) begin
      rd_addr = '0;
    end else if (cmd_i.run_step) begin
      rd_addr = stat_o.run_last ? '0 : idx_q + IdxW'(1);
    end else begin
      rd_addr = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_en && !full) begin
      mem_q[cnt_q[IdxW-1:0]] <= byte_in_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    trunc_d     = trunc_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      unique case (cmd_i.out_src)
        SRC_DATA: begin
          out_kind_d = KIND_DATA;
          out_byte_d = byte_in_i;
          last_d     = 1'b1;
          trunc_d    = 1'b0;
        end
        SRC_REPLY_IAC: begin
          out_kind_d = KIND_REPLY;
          out_byte_d = C_IAC;
          last_d     = 1'b0;
          trunc_d    = 1'b0;
        end
        SRC_REPLY_ANS: begin
          out_kind_d = KIND_REPLY;
          out_byte_d = ans_q;
          last_d     = 1'b0;
          trunc_d    = 1'b0;
        end
        SRC_REPLY_OPT: begin
          out_kind_d = KIND_REPLY;
          out_byte_d = opt_q;
          last_d     = 1'b1;
          trunc_d    = 1'b0;
        end
        SRC_EMPTY: begin
          out_kind_d = KIND_EMPTY;
          out_byte_d = 8'd0;
          last_d     = 1'b1;
          trunc_d    = ovf_q;
        end
        SRC_RUN: begin
          out_kind_d = KIND_SUB;
          out_byte_d = rd_data_q;
          last_d     = stat_o.run_last;
          trunc_d    = ovf_q;
        end
        default: begin
          out_kind_d = KIND_DATA;
          out_byte_d = 8'd0;
          last_d     = 1'b1;
          trunc_d    = 1'b0;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 8'd0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.save_cmd) begin
        pend_q <= byte_in_i;
      end
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    trunc_q    <= trunc_d;
    if (cmd_i.reply_save) begin
      ans_q <= ans_d;
      opt_q <= byte_in_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign truncated_o = trunc_q;

endmodule

`default_nettype wire

// ===== rtl/tisp_ctrl.sv =====
`default_nettype none

module tisp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tisp_pkg::dp_stat_t stat_i,
  output tisp_pkg::dp_cmd_t       cmd_o
);
  import tisp_pkg::*;

  typedef enum logic [4:0] {
    P_DATA   = 5'b00001,
    P_IAC    = 5'b00010,
    P_NEGO   = 5'b00100,
    P_SB     = 5'b01000,
    P_SB_IAC = 5'b10000
  } parse_e;

  typedef enum logic [3:0] {
    Q_IDLE      = 4'b0001,
    Q_REPLY_ANS = 4'b0010,
    Q_REPLY_OPT = 4'b0100,
    Q_RUN       = 4'b1000
  } seq_e;

  parse_e parse_q, parse_d;
  seq_e   seq_q, seq_d;
  logic   take;

  assign in_ready_o = (seq_q == Q_IDLE) && stat_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    parse_d = parse_q;
    seq_d   = seq_q;
    cmd_o   = '0;
    cmd_o.out_src    = SRC_DATA;
    cmd_o.run_active = (seq_q == Q_RUN);

    unique case (seq_q)
      Q_IDLE: begin
        if (take) begin
          unique case (parse_q)
            P_IAC: begin
              if (stat_i.is_iac) begin
                cmd_o.out_load = 1'b1;
                parse_d = P_DATA;
              end else if (stat_i.is_cmd) begin
                cmd_o.save_cmd = 1'b1;
                parse_d = P_NEGO;
              end else if (stat_i.is_sb) begin
                cmd_o.clr_sub = 1'b1;
                parse_d = P_SB;
              end else begin
                parse_d = P_DATA;
              end
            end
            P_NEGO: begin
              if (stat_i.cmd_known) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_src    = SRC_REPLY_IAC;
                cmd_o.reply_save = 1'b1;
                seq_d = Q_REPLY_ANS;
              end
              parse_d = P_DATA;
            end
            P_SB: begin
              if (stat_i.is_iac) begin
                parse_d = P_SB_IAC;
              end else begin
                cmd_o.store_en = 1'b1;
              end
            end
            P_SB_IAC: begin
              if (stat_i.is_iac) begin
                cmd_o.store_en = 1'b1;
                parse_d = P_SB;
              end else if (stat_i.is_se) begin
                if (stat_i.cnt_zero) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_src  = SRC_EMPTY;
                  cmd_o.clr_sub  = 1'b1;
                end else begin
                  cmd_o.run_start = 1'b1;
                  seq_d = Q_RUN;
                end
                parse_d = P_DATA;
              end else begin
                cmd_o.clr_sub = 1'b1;
                parse_d = P_DATA;
              end
            end
            default: begin
              if (stat_i.is_iac) begin
                parse_d = P_IAC;
              end else begin
                cmd_o.out_load = 1'b1;
                parse_d = P_DATA;
              end
            end
          endcase
        end
      end
      Q_REPLY_ANS: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = SRC_REPLY_ANS;
          seq_d = Q_REPLY_OPT;
        end
      end
      Q_REPLY_OPT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = SRC_REPLY_OPT;
          seq_d = Q_IDLE;
        end
      end
      Q_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = SRC_RUN;
          cmd_o.run_step = 1'b1;
          if (stat_i.run_last) begin
            cmd_o.clr_sub = 1'b1;
            seq_d = Q_IDLE;
          end
        end
      end
      default: begin
        seq_d = Q_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= P_DATA;
      seq_q   <= Q_IDLE;
    end else begin
      parse_q <= parse_d;
      seq_q   <= seq_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/telnet_iac_stream_parser_core.sv =====
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  byte_in_i
// out      out_valid_o/out_ready_i out_kind_o, out_byte_o, last_o, truncated_o
//
// One byte per cycle while each byte gives at most one item and the output is free; the single
// output register frees as it is taken.
// A negotiation reply holds input through Q_REPLY_ANS and Q_REPLY_OPT, a
// subnegotiation run of N stored bytes through Q_RUN, one store read per free cycle.
// Output stalls back-pressure the input through in_ready_o.
// Reset: parser in data state, store empty; no clearing pass.
module telnet_iac_stream_parser_core #(
  parameter int SubnegDepth = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o,
  output logic            truncated_o
);
  import tisp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tisp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tisp_dp #(
    .SubnegDepth (SubnegDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in_i   (byte_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .truncated_o (truncated_o)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tisp_pkg::*;

  localparam int SubDepth    = 64;
  localparam int WatchLimit  = 2000;
  localparam int RandomItems = 160;

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_NEGO,
    PS_SUB,
    PS_SUB_IAC
  } parse_state_e;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } tn_out_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] byte_in   = 8'd0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_trunc;

  parse_state_e ps       = PS_DATA;
  logic [7:0]   pend_cmd = 8'd0;
  logic [7:0]   sub_buf [SubDepth];
  int           sub_cnt  = 0;
  logic         sub_ovf  = 1'b0;

  tn_out_t awaited_q[$];
  int      errors      = 0;
  int      sent        = 0;
  bit      calm        = 1'b0;
  int      hold_req    = 0;
  int      idle_cycles = 0;

  telnet_iac_stream_parser_core #(
    .SubnegDepth(SubDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .byte_in_i  (byte_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_kind_o (out_kind),
    .out_byte_o (out_byte),
    .last_o     (out_last),
    .truncated_o(out_trunc)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit option_agreed(logic [7:0] opt);
    return opt inside {OPT_BINARY, OPT_ECHO, OPT_SGA, OPT_COMPORT};
  endfunction

  function automatic void push_out(out_kind_e k, logic [7:0] d, logic l, logic t);
    awaited_q.push_back('{kind: k, data: d, last: l, trunc: t});
  endfunction

  function automatic void sub_keep(logic [7:0] b);
    if (sub_cnt < SubDepth) begin
      sub_buf[sub_cnt] = b;
      sub_cnt++;
    end else begin
      sub_ovf = 1'b1;
    end
  endfunction

  function automatic void parse_net_byte(logic [7:0] b);
    logic [7:0] ans;
    logic       ok;
    logic       reply;
    ans   = C_DONT;
    reply = 1'b1;
    case (ps)
      PS_IAC: begin
        if (b == C_IAC) begin
          push_out(KIND_DATA, C_IAC, 1'b1, 1'b0);
          ps = PS_DATA;
        end else if (b inside {C_WILL, C_WONT, C_DO, C_DONT}) begin
          pend_cmd = b;
          ps = PS_NEGO;
        end else if (b == C_SB) begin
          sub_cnt = 0;
          sub_ovf = 1'b0;
          ps = PS_SUB;
        end else begin
          ps = PS_DATA;
        end
      end
      PS_NEGO: begin
        ok = option_agreed(b);
        case (pend_cmd)
          C_DO:    ans = ok ? C_WILL : C_WONT;
          C_WILL:  ans = ok ? C_DO : C_DONT;
          C_DONT:  ans = C_WONT;
          C_WONT:  ans = C_DONT;
          default: reply = 1'b0;
        endcase
        if (reply) begin
          push_out(KIND_REPLY, C_IAC, 1'b0, 1'b0);
          push_out(KIND_REPLY, ans, 1'b0, 1'b0);
          push_out(KIND_REPLY, b, 1'b1, 1'b0);
        end
        ps = PS_DATA;
      end
      PS_SUB: begin
        if (b == C_IAC) ps = PS_SUB_IAC;
        else sub_keep(b);
      end
      PS_SUB_IAC: begin
        if (b == C_IAC) begin
          sub_keep(C_IAC);
          ps = PS_SUB;
        end else begin
          if (b == C_SE) begin
            if (sub_cnt == 0) begin
              push_out(KIND_EMPTY, 8'd0, 1'b1, sub_ovf);
            end else begin
              for (int i = 0; i < sub_cnt; i++)
                push_out(KIND_SUB, sub_buf[i], i == sub_cnt - 1, sub_ovf);
            end
          end
          sub_cnt = 0;
          sub_ovf = 1'b0;
          ps = PS_DATA;
        end
      end
      default: begin
        if (b == C_IAC) ps = PS_IAC;
        else push_out(KIND_DATA, b, 1'b1, 1'b0);
      end
    endcase
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    parse_net_byte(b);
    sent++;
  endtask

  // n stored bytes; an IAC in the payload goes out doubled
  task automatic send_sub_payload(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b);
      if (b == C_IAC) send_byte(C_IAC);
    end
  endtask

  task automatic send_cmd(input logic [7:0] cmd, input logic [7:0] opt);
    send_byte(C_IAC);
    send_byte(cmd);
    send_byte(opt);
  endtask

  task automatic test_plain_data();
    calm = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(C_IAC);
    send_byte(C_IAC);
    send_byte(C_IAC);
    send_byte(8'd241);
    calm = 1'b0;
  endtask

  task automatic test_negotiation();
    send_cmd(C_DO, OPT_ECHO);
    send_cmd(C_WILL, 8'd200);
    send_cmd(C_DONT, OPT_SGA);
    send_cmd(C_WONT, 8'd255);
  endtask

  task automatic test_subneg();
    send_byte(C_IAC);
    send_byte(C_SB);
    send_byte(8'h61);
    send_byte(C_IAC);
    send_byte(C_IAC);
    send_byte(C_IAC);
    send_byte(C_SE);
    send_byte(C_IAC);
    send_byte(C_SB);
    send_byte(C_IAC);
    send_byte(C_SE);
    send_byte(C_IAC);
    send_byte(C_SB);
    send_byte(8'h01);
    send_byte(C_IAC);
    send_byte(8'h07);
  endtask

  task automatic test_subneg_full();
    send_byte(C_IAC);
    send_byte(C_SB);
    send_sub_payload(SubDepth);
    send_byte(C_IAC);
    send_byte(C_SE);
    // escaped IAC arrives after the store is full
    send_byte(C_IAC);
    send_byte(C_SB);
    send_sub_payload(SubDepth);
    send_byte(C_IAC);
    send_byte(C_IAC);
    send_sub_payload(2);
    send_byte(C_IAC);
    send_byte(C_SE);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_req = 200;
    for (int i = 0; i < 30; i++) send_byte(8'($urandom_range(0, 254)));
    send_byte(C_IAC);
    send_byte(C_SB);
    send_sub_payload(10);
    send_byte(C_IAC);
    send_byte(C_SE);
    send_cmd(C_DO, OPT_COMPORT);
    calm = 1'b0;
  endtask

  task automatic test_random();
    int         start;
    int         r;
    int         len;
    logic [7:0] b;
    start = sent;
    while (sent - start < RandomItems) begin
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_byte(8'($urandom_range(0, 254)));
      end else if (r < 42) begin
        send_byte(C_IAC);
        send_byte(C_IAC);
      end else if (r < 70) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 3))
            0:       b = OPT_BINARY;
            1:       b = OPT_ECHO;
            2:       b = OPT_SGA;
            default: b = OPT_COMPORT;
          endcase
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_cmd(8'(C_WILL + $urandom_range(0, 3)), b);
      end else if (r < 88) begin
        send_byte(C_IAC);
        send_byte(C_SB);
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        send_sub_payload(len);
        r = $urandom_range(0, 9);
        if (r < 8) begin
          send_byte(C_IAC);
          send_byte(C_SE);
        end else if (r == 8) begin
          do b = 8'($urandom_range(0, 255)); while (b == C_IAC || b == C_SE);
          send_byte(C_IAC);
          send_byte(b);
        end
      end else if (r < 94) begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {C_IAC, C_SB, C_WILL, C_WONT, C_DO, C_DONT});
        send_byte(C_IAC);
        send_byte(b);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin : rx
    int      stall;
    tn_out_t e;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected item: kind %0d byte %0d", out_kind, out_byte);
          errors++;
        end else begin
          e = awaited_q.pop_front();
          if (out_kind != e.kind) begin
            $error("out_kind: expected %0d, got %0d", e.kind, out_kind);
            errors++;
          end
          if (out_byte != e.data) begin
            $error("out_byte: expected %0d, got %0d", e.data, out_byte);
            errors++;
          end
          if (out_last != e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            errors++;
          end
          if (out_trunc != e.trunc) begin
            $error("truncated: expected %0d, got %0d", e.trunc, out_trunc);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall == 0 && !calm && $urandom_range(0, 99) < 20) stall = stall_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("** telnet_iac_stream_parser_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_data();
    test_negotiation();
    test_subneg();
    test_subneg_full();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** telnet_iac_stream_parser_core: PASSED **");
    end else begin
      $display("** telnet_iac_stream_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
